/* rtl/core/u8u16_pkg.sv */
// Package: types, constants and microcode store of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

	localparam int StepW = 3;
	typedef logic [StepW-1:0] step_t;

	// Microprogram addresses
	localparam step_t StWait  = 3'd0;
	localparam step_t StDisp  = 3'd1;
	localparam step_t StFlush = 3'd2;
	localparam step_t StBad   = 3'd3;
	localparam step_t StBmp   = 3'd4;
	localparam step_t StHigh  = 3'd5;
	localparam step_t StLow   = 3'd6;

	localparam logic [15:0] ReplUnit  = 16'hFFFD;
	localparam logic [15:0] HighBase  = 16'hD800;
	localparam logic [15:0] LowBase   = 16'hDC00;
	localparam logic [20:0] SurFirst  = 21'h00D800;
	localparam logic [20:0] SurLast   = 21'h00DFFF;
	localparam logic [20:0] Min2      = 21'h000080;
	localparam logic [20:0] Min3      = 21'h000800;
	localparam logic [20:0] Min4      = 21'h010000;
	localparam logic [20:0] MaxCp     = 21'h10FFFF;

	typedef enum logic [2:0] {EmNone, EmRepl, EmBmp, EmHigh, EmLow} emit_t;
	typedef enum logic [1:0] {ShNone, ShOne, ShLen} shift_t;
	typedef enum logic [1:0] {JmpGoto, JmpAccept, JmpDispatch} jump_t;
	// Dispatch offsets from StFlush; order must match the microprogram layout
	typedef enum logic [1:0] {ClsEnd, ClsBad, ClsBmp, ClsSupp} cls_t;

	typedef struct packed {
		logic   accept;
		logic   flush;
		emit_t  emit;
		shift_t shift;
		jump_t  jump;
		step_t  tgt;
	} cw_t;

	function automatic cw_t ucode(step_t a);
		cw_t w;
		w = '{accept: 1'b0, flush: 1'b0, emit: EmNone, shift: ShNone,
			jump: JmpGoto, tgt: StWait};
		unique case (a)
			StWait: begin
				w.accept = 1'b1;
				w.jump   = JmpAccept;
				w.tgt    = StDisp;
			end
			StDisp: begin
				w.jump = JmpDispatch;
				w.tgt  = StFlush;
			end
			StFlush: begin
				w.flush = 1'b1;
				w.tgt   = StWait;
			end
			StBad: begin
				w.emit  = EmRepl;
				w.shift = ShOne;
				w.tgt   = StDisp;
			end
			StBmp: begin
				w.emit  = EmBmp;
				w.shift = ShLen;
				w.tgt   = StDisp;
			end
			StHigh: begin
				w.emit = EmHigh;
				w.tgt  = StLow;
			end
			StLow: begin
				w.emit  = EmLow;
				w.shift = ShLen;
				w.tgt   = StDisp;
			end
			default: begin
				w.tgt = StWait;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/utf8_to_utf16_stream_decoder_unit.sv */
// Top level: microcoded UTF-8 to UTF-16 stream decoder.
//
// Input channel: data_byte and discard_pending, handshake byte_valid/byte_ready.
// Output channel: code_unit, is_replacement, last_of_run, handshake
// unit_valid/unit_ready. last_of_run marks the final unit caused by one byte;
// a byte that only extends an unfinished sequence gives no unit at all.
// One item is worked on at a time by a seven-step microprogram. Each item
// passes the wait, dispatch and flush steps; each code point or replacement
// it completes adds an emit step (bad or BMP, or high then low for a
// surrogate pair) and a return to dispatch. A one-unit staging register sits
// in front of the output register. Each unit sits in staging until the next
// unit or the end of the item is known; only then does it move out.
// A stalled receiver holds the output register; a step that must push a unit
// then waits while staging is full. byte_ready is high only in the wait step.
// Reset empties the held bytes, the staging and the output register.
module utf8_to_utf16_stream_decoder_unit
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        discard_pending,
	output logic        unit_valid,
	input  logic        unit_ready,
	output logic [15:0] code_unit,
	output logic        is_replacement,
	output logic        last_of_run
);

	step_t       step_q;
	logic [7:0]  buf_q [4];
	logic [2:0]  cnt_q;
	logic        stg_v_q;
	logic [15:0] stg_code_q;
	logic        stg_repl_q;
	logic        out_v_q;
	logic [15:0] out_code_q;
	logic        out_repl_q;
	logic        out_last_q;

	cw_t         cw;
	cls_t        cls;
	logic [2:0]  len;
	logic [20:0] cp;
	logic [19:0] sup;
	logic        cont_ok;
	logic        range_ok;
	logic [2:0]  sh_amt;
	logic [15:0] new_code;
	logic        new_repl;
	logic        need_push;
	logic        push_ok;
	logic        go;
	logic        move_out;
	logic        take;
	logic [2:0]  base_cnt;
	step_t       step_d;

	// Decode the window starting at the oldest byte
	always_comb begin
		priority if (!buf_q[0][7])              len = 3'd1;
		else if (buf_q[0][7:5] == 3'b110)        len = 3'd2;
		else if (buf_q[0][7:4] == 4'b1110)       len = 3'd3;
		else if (buf_q[0][7:3] == 5'b11110)      len = 3'd4;
		else                                     len = 3'd0;
	end

	always_comb begin
		cont_ok  = 1'b1;
		range_ok = 1'b1;
		cp       = {13'd0, buf_q[0]};
		unique case (len)
			3'd2: begin
				cont_ok  = buf_q[1][7:6] == 2'b10;
				cp       = {10'd0, buf_q[0][4:0], buf_q[1][5:0]};
				range_ok = cp >= Min2;
			end
			3'd3: begin
				cont_ok  = buf_q[1][7:6] == 2'b10 && buf_q[2][7:6] == 2'b10;
				cp       = {5'd0, buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]};
				range_ok = cp >= Min3 && !(cp >= SurFirst && cp <= SurLast);
			end
			3'd4: begin
				cont_ok  = buf_q[1][7:6] == 2'b10 && buf_q[2][7:6] == 2'b10 &&
					buf_q[3][7:6] == 2'b10;
				cp       = {buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
				range_ok = cp >= Min4 && cp <= MaxCp;
			end
			default: begin
				cp = {13'd0, buf_q[0]};
			end
		endcase
	end

	assign sup = 20'(cp - Min4);

	always_comb begin
		priority if (cnt_q == 3'd0)       cls = ClsEnd;
		else if (len == 3'd0)             cls = ClsBad;
		else if (cnt_q < len)             cls = ClsEnd;
		else if (!cont_ok || !range_ok)   cls = ClsBad;
		else if (len == 3'd4)             cls = ClsSupp;
		else                              cls = ClsBmp;
	end

	assign cw = ucode(step_q);

	always_comb begin
		unique case (cw.shift)
			ShOne:   sh_amt = 3'd1;
			ShLen:   sh_amt = len;
			default: sh_amt = 3'd0;
		endcase
	end

	always_comb begin
		new_repl = 1'b0;
		unique case (cw.emit)
			EmRepl: begin
				new_code = ReplUnit;
				new_repl = 1'b1;
			end
			EmBmp:   new_code = cp[15:0];
			EmHigh:  new_code = HighBase + {6'd0, sup[19:10]};
			EmLow:   new_code = LowBase + {6'd0, sup[9:0]};
			default: new_code = ReplUnit;
		endcase
	end

	assign byte_ready = cw.accept;
	assign take       = byte_valid && cw.accept;
	assign need_push  = (cw.emit != EmNone) || cw.flush;
	assign push_ok    = !stg_v_q || !out_v_q || unit_ready;
	assign go         = !need_push || push_ok;
	assign move_out   = go && need_push && stg_v_q;
	assign base_cnt   = discard_pending ? 3'd0 : cnt_q;

	always_comb begin
		unique case (cw.jump)
			JmpAccept:   step_d = take ? cw.tgt : step_q;
			JmpDispatch: step_d = step_t'(cw.tgt + {1'b0, cls});
			default:     step_d = go ? cw.tgt : step_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= StWait;
			cnt_q   <= 3'd0;
			stg_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (take) begin
				cnt_q <= base_cnt + 3'd1;
			end else if (go && cw.shift != ShNone) begin
				cnt_q <= cnt_q - sh_amt;
			end
			if (go && cw.emit != EmNone) begin
				stg_v_q <= 1'b1;
			end else if (go && cw.flush) begin
				stg_v_q <= 1'b0;
			end
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (unit_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			buf_q[base_cnt[1:0]] <= data_byte;
		end else if (go && cw.shift != ShNone) begin
			for (int j = 0; j < 4; j++) begin
				logic [2:0] src;
				src = 3'(j) + sh_amt;
				if (src < 3'd4) begin
					buf_q[j] <= buf_q[src[1:0]];
				end
			end
		end
		if (go && cw.emit != EmNone) begin
			stg_code_q <= new_code;
			stg_repl_q <= new_repl;
		end
		if (move_out) begin
			out_code_q <= stg_code_q;
			out_repl_q <= stg_repl_q;
			out_last_q <= cw.flush;
		end
	end

	assign unit_valid     = out_v_q;
	assign code_unit      = out_code_q;
	assign is_replacement = out_repl_q;
	assign last_of_run    = out_last_q;

	// Between items nothing is staged and at most three bytes are held
	a_wait_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == StWait) |-> (!stg_v_q && cnt_q <= 3'd3))
		else $error("staged unit or overfull window while waiting");

	// A non-final unit always has its successor staged behind it
	a_successor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_last_q) |-> stg_v_q)
		else $error("non-final unit without successor");

	// Consumption never exceeds the bytes present
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(go && cw.shift != ShNone) |-> (sh_amt != 3'd0 && sh_amt <= cnt_q))
		else $error("window shift beyond held bytes");

	// A new item enters only in the wait step
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (step_q == StDisp && cnt_q != 3'd0))
		else $error("accepted item not dispatched");

endmodule
